// ===== design/gle_pkg.sv =====
// Shared types and constants of the GIF LZW encoder.
// Holds the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package gle_pkg;

	localparam int unsigned DICT_CODES_DEF = 4096;
	localparam int unsigned CODE_W         = 12;   // widest LZW code
	localparam int unsigned NEXT_W         = 13;   // next free code, may reach 4096
	localparam int unsigned SIZE_W         = 4;    // min code size / code width
	localparam int unsigned SYM_W          = 8;
	localparam int unsigned ENTRY_W        = CODE_W + SYM_W;
	localparam int unsigned ACC_W          = 20;   // 7 pending bits + 12 code bits
	localparam int unsigned CNT_W          = 5;
	localparam logic [SIZE_W-1:0] MAX_WIDTH    = 4'd12;
	localparam logic [SIZE_W-1:0] MIN_SIZE_RST = 4'd8;
	localparam logic [SIZE_W-1:0] MIN_SIZE_LO  = 4'd2;
	localparam logic [SIZE_W-1:0] MIN_SIZE_HI  = 4'd8;

	// commands from controller to datapath
	typedef struct packed {
		logic load;        // latch input symbol
		logic start;       // first symbol: init dictionary, emit clear
		logic scan;        // dictionary scan step
		logic take_hit;    // prefix <= matched code
		logic put_prefix;  // emit current prefix
		logic add_entry;   // add new dictionary entry, prefix <= symbol
		logic put_clear;   // emit clear and reset dictionary
		logic put_end;     // emit end code, final of frame
		logic end_frame;   // leave frame
	} gle_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic in_frame;
		logic last;
		logic hit;
		logic exhausted;
		logic full;
		logic pk_ready;
		logic pk_idle;
	} gle_stat_t;

endpackage

`default_nettype wire

// ===== design/gif_lzw_encoder_unit.sv =====
// GIF LZW encoder top level: controller plus datapath.
// Depends on gle_pkg, gle_ctrl, gle_datapath (gle_dict_ram, gle_packer).
//
// Takes palette index symbols of one frame on s_axis (tlast marks the
// frame's last symbol) and gives the LZW byte stream, codes packed LSB
// first, on m_axis (tlast on the frame's final byte). min_code_size is
// written through cfg_we/cfg_wdata between frames. The dictionary is
// searched linearly through one memory read port, one entry per cycle,
// so the search for a symbol grows with the entries already added in
// the frame. When the dictionary is full, a miss also sends a clear
// code; a frame end sends the last prefix and the end code and waits
// until the packer has passed on its last bytes. Each step that sends
// a code also waits while the packer holds a full byte or the padded
// final byte. An output register decouples the byte stream, so the
// block keeps working while a byte waits.
`default_nettype none

module gif_lzw_encoder_unit
	import gle_pkg::*;
#(
	parameter int unsigned DICT_CODES = DICT_CODES_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire [SIZE_W-1:0] cfg_wdata,      // min_code_size
	input  wire              s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire [7:0]        s_axis_tdata,   // [7:0] symbol
	input  wire              s_axis_tlast,   // frame_end
	output logic             m_axis_tvalid,
	input  wire              m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
	output logic             m_axis_tlast    // last_byte
);

	gle_cmd_t  cmd;
	gle_stat_t stat;

	gle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gle_datapath #(
		.DICT_CODES(DICT_CODES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_symbol     (s_axis_tdata),
		.in_last       (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== design/gle_dict_ram.sv =====
// Dictionary memory: prefix code and symbol per LZW code.
// One write port, one registered read port. Uses gle_pkg.
`default_nettype none

module gle_dict_ram
	import gle_pkg::*;
#(
	parameter int unsigned DICT_CODES = DICT_CODES_DEF
) (
	input  wire                          clk,
	input  wire                          we,
	input  wire [$clog2(DICT_CODES)-1:0] waddr,
	input  wire [ENTRY_W-1:0]            wdata,
	input  wire                          re,
	input  wire [$clog2(DICT_CODES)-1:0] raddr,
	output logic [ENTRY_W-1:0]           rdata
);

	logic [ENTRY_W-1:0] mem [DICT_CODES];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/gle_packer.sv =====
// Bit packer: joins variable width codes LSB first into bytes.
// Holds the output register of the byte stream. Uses gle_pkg.
`default_nettype none

module gle_packer
	import gle_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                put,
	input  wire [CODE_W-1:0]   code,
	input  wire [SIZE_W-1:0]   width,
	input  wire                final_code,
	output logic               ready,
	output logic               idle,
	output logic               m_axis_tvalid,
	input  wire                m_axis_tready,
	output logic [7:0]         m_axis_tdata,
	output logic               m_axis_tlast
);

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             final_q;
	logic             full_byte;
	logic             busy;
	logic             emit;

	assign full_byte = cnt_q >= CNT_W'(8);
	assign busy      = full_byte || (final_q && cnt_q != '0);
	assign ready     = !busy;
	assign idle      = !busy;
	assign emit      = busy && (!m_axis_tvalid || m_axis_tready);

	// accumulator and byte output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= '0;
			cnt_q         <= '0;
			final_q       <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tlast  <= 1'b0;
		end else begin
			if (!put && emit)
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready)
				m_axis_tvalid <= 1'b0;
			if (put) begin
				acc_q   <= (acc_q & ACC_W'(8'hFF)) | (ACC_W'(code) << cnt_q[2:0]);
				cnt_q   <= CNT_W'(cnt_q[2:0]) + CNT_W'(width);
				final_q <= final_code;
			end else if (emit) begin
				m_axis_tdata  <= acc_q[7:0];
				if (full_byte) begin
					m_axis_tlast <= final_q && cnt_q == CNT_W'(8);
					acc_q        <= acc_q >> 8;
					cnt_q        <= cnt_q - CNT_W'(8);
					if (cnt_q == CNT_W'(8))
						final_q <= 1'b0;
				end else begin
					// zero padded final byte
					m_axis_tlast <= 1'b1;
					acc_q        <= '0;
					cnt_q        <= '0;
					final_q      <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/gle_datapath.sv =====
// Encoder datapath: registers, dictionary scan and update, code mux.
// Instantiates gle_dict_ram and gle_packer. Uses gle_pkg.
`default_nettype none

module gle_datapath
	import gle_pkg::*;
#(
	parameter int unsigned DICT_CODES = DICT_CODES_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  gle_cmd_t           cmd,
	output gle_stat_t          stat,
	input  wire                cfg_we,
	input  wire [SIZE_W-1:0]   cfg_wdata,
	input  wire [SYM_W-1:0]    in_symbol,
	input  wire                in_last,
	output logic               m_axis_tvalid,
	input  wire                m_axis_tready,
	output logic [7:0]         m_axis_tdata,
	output logic               m_axis_tlast
);

	localparam int unsigned AW = $clog2(DICT_CODES);

	logic [SIZE_W-1:0]  msz_q;
	logic               in_frame_q;
	logic [SYM_W-1:0]   sym_q;
	logic               last_q;
	logic [CODE_W-1:0]  prefix_q;
	logic [NEXT_W-1:0]  next_free_q;
	logic [SIZE_W-1:0]  width_q;
	logic [NEXT_W-1:0]  scan_q;
	logic               rd_v_s1;
	logic [CODE_W-1:0]  rd_code_s1;
	logic [ENTRY_W-1:0] rd_data;

	logic [SIZE_W-1:0]  msz;
	logic [CODE_W-1:0]  clear_code;
	logic [NEXT_W-1:0]  first_free;
	logic [SIZE_W-1:0]  first_width;
	logic               rd_en;
	logic               pk_put;
	logic [CODE_W-1:0]  pk_code;
	logic [SIZE_W-1:0]  pk_width;
	logic               pk_ready;
	logic               pk_idle;

	// clamped minimum code size and derived codes
	always_comb begin
		if (msz_q < MIN_SIZE_LO)
			msz = MIN_SIZE_LO;
		else if (msz_q > MIN_SIZE_HI)
			msz = MIN_SIZE_HI;
		else
			msz = msz_q;
		clear_code  = CODE_W'(1) << msz;
		first_free  = NEXT_W'(clear_code) + NEXT_W'(2);
		first_width = msz + SIZE_W'(1);
	end

	assign rd_en = cmd.scan && (scan_q < next_free_q);

	// control and dictionary registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msz_q       <= MIN_SIZE_RST;
			in_frame_q  <= 1'b0;
			last_q      <= 1'b0;
			prefix_q    <= '0;
			next_free_q <= '0;
			width_q     <= '0;
			scan_q      <= '0;
			rd_v_s1     <= 1'b0;
		end else begin
			if (cfg_we && !in_frame_q)
				msz_q <= cfg_wdata;
			if (cmd.load) begin
				last_q  <= in_last;
				scan_q  <= first_free;
				rd_v_s1 <= 1'b0;
			end
			if (cmd.scan) begin
				rd_v_s1 <= rd_en;
				if (rd_en)
					scan_q <= scan_q + NEXT_W'(1);
			end
			if (cmd.start) begin
				in_frame_q  <= 1'b1;
				next_free_q <= first_free;
				width_q     <= first_width;
				prefix_q    <= CODE_W'(sym_q);
			end
			if (cmd.take_hit)
				prefix_q <= rd_code_s1;
			if (cmd.add_entry) begin
				next_free_q <= next_free_q + NEXT_W'(1);
				prefix_q    <= CODE_W'(sym_q);
				if (next_free_q == (NEXT_W'(1) << width_q) && width_q < MAX_WIDTH)
					width_q <= width_q + SIZE_W'(1);
			end
			if (cmd.put_clear) begin
				next_free_q <= first_free;
				width_q     <= first_width;
				prefix_q    <= CODE_W'(sym_q);
			end
			if (cmd.end_frame)
				in_frame_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load)
			sym_q <= in_symbol & SYM_W'(clear_code - CODE_W'(1));
		if (cmd.scan)
			rd_code_s1 <= scan_q[CODE_W-1:0];
	end

	gle_dict_ram #(
		.DICT_CODES(DICT_CODES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.add_entry),
		.waddr (next_free_q[AW-1:0]),
		.wdata ({prefix_q, sym_q}),
		.re    (rd_en),
		.raddr (scan_q[AW-1:0]),
		.rdata (rd_data)
	);

	// code selection for the packer
	always_comb begin
		pk_put   = cmd.start || cmd.put_prefix || cmd.put_clear || cmd.put_end;
		pk_code  = prefix_q;
		pk_width = width_q;
		if (cmd.start) begin
			pk_code  = clear_code;
			pk_width = first_width;
		end else if (cmd.put_clear) begin
			pk_code = clear_code;
		end else if (cmd.put_end) begin
			pk_code = clear_code + CODE_W'(1);
		end
	end

	gle_packer u_packer (
		.clk           (clk),
		.arst_n        (arst_n),
		.put           (pk_put),
		.code          (pk_code),
		.width         (pk_width),
		.final_code    (cmd.put_end),
		.ready         (pk_ready),
		.idle          (pk_idle),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// status
	always_comb begin
		stat.in_frame  = in_frame_q;
		stat.last      = last_q;
		stat.hit       = rd_v_s1 && rd_data == {prefix_q, sym_q};
		stat.exhausted = !rd_v_s1 && scan_q >= next_free_q;
		stat.full      = next_free_q >= NEXT_W'(DICT_CODES);
		stat.pk_ready  = pk_ready;
		stat.pk_idle   = pk_idle;
	end

endmodule

`default_nettype wire

// ===== design/gle_ctrl.sv =====
// Encoder controller: sequences start, scan, miss handling and frame end.
// Drives gle_cmd_t, reads gle_stat_t. Uses gle_pkg.
`default_nettype none

module gle_ctrl
	import gle_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_ready,
	input  gle_stat_t stat,
	output gle_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_MISS,
		ST_CLEAR,
		ST_FIN_P,
		ST_FIN_E,
		ST_FIN_W
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	// commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.in_frame ? ST_SCAN : ST_START;
				end
			end
			ST_START: begin
				if (stat.pk_ready) begin
					cmd.start = 1'b1;
					state_d   = stat.last ? ST_FIN_P : ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.hit) begin
					cmd.take_hit = 1'b1;
					state_d      = stat.last ? ST_FIN_P : ST_IDLE;
				end else if (stat.exhausted) begin
					state_d = ST_MISS;
				end
			end
			ST_MISS: begin
				if (stat.pk_ready) begin
					cmd.put_prefix = 1'b1;
					if (!stat.full) begin
						cmd.add_entry = 1'b1;
						state_d       = stat.last ? ST_FIN_P : ST_IDLE;
					end else begin
						state_d = ST_CLEAR;
					end
				end
			end
			ST_CLEAR: begin
				if (stat.pk_ready) begin
					cmd.put_clear = 1'b1;
					state_d       = stat.last ? ST_FIN_P : ST_IDLE;
				end
			end
			ST_FIN_P: begin
				if (stat.pk_ready) begin
					cmd.put_prefix = 1'b1;
					state_d        = ST_FIN_E;
				end
			end
			ST_FIN_E: begin
				if (stat.pk_ready) begin
					cmd.put_end = 1'b1;
					state_d     = ST_FIN_W;
				end
			end
			ST_FIN_W: begin
				if (stat.pk_idle) begin
					cmd.end_frame = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for gif_lzw_encoder_unit: random and directed frames of symbols,
// checked byte by byte against a behavioural LZW predictor held here.
// Depends on gle_pkg and the encoder RTL.
`default_nettype none

module tb_top;
	import gle_pkg::*;

	typedef struct {
		bit          is_cfg;
		logic [3:0]  cfg;
		logic [7:0]  sym;
		bit          last;
		bit          calm;
	} stim_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} lzw_byte_t;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              cfg_we = 0;
	logic [SIZE_W-1:0] cfg_wdata = '0;
	logic              s_axis_tvalid = 0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;
	logic              s_axis_tlast = 0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 0;
	logic [7:0]        m_axis_tdata;
	logic              m_axis_tlast;

	stim_t     pending_q[$];
	lzw_byte_t byte_q[$];
	int        errors = 0;
	int        quiet = 0;
	bit        calm_now = 0;

	// predictor state
	logic [11:0] dict_prefix[DICT_CODES_DEF];
	logic [7:0]  dict_sym[DICT_CODES_DEF];
	logic [12:0] next_code = '0;
	logic [3:0]  code_w = '0;
	logic [11:0] prefix = '0;
	logic [7:0]  pbits = '0;
	logic [2:0]  pcount = '0;
	logic        framing = 0;
	logic [3:0]  size_reg = MIN_SIZE_RST;

	gif_lzw_encoder_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// queue one expected byte
	task automatic add_byte(input logic [7:0] d);
		lzw_byte_t b;
		b.data = d;
		b.last = 1'b0;
		byte_q.insert(byte_q.size(), b);
	endtask

	// append one code of w bits to the byte stream, LSB first
	task automatic pack_code(input logic [11:0] code, input logic [3:0] w);
		logic [19:0] acc;
		int cnt;
		acc = 20'(pbits) | (20'(code) << pcount);
		cnt = pcount + w;
		while (cnt >= 8) begin
			add_byte(acc[7:0]);
			acc = acc >> 8;
			cnt -= 8;
		end
		pbits = acc[7:0];
		pcount = cnt[2:0];
	endtask

	task automatic lzw_encode(input logic [7:0] raw, input logic fend);
		logic [3:0]  msz;
		logic [12:0] clr;
		logic [7:0]  sym;
		logic [12:0] c;
		logic        hit;
		int          first_out;
		msz = (size_reg < MIN_SIZE_LO) ? MIN_SIZE_LO :
			(size_reg > MIN_SIZE_HI) ? MIN_SIZE_HI : size_reg;
		clr = 13'd1 << msz;
		sym = raw & 8'(clr - 13'd1);
		first_out = byte_q.size();
		if (!framing) begin
			framing = 1;
			next_code = clr + 13'd2;
			code_w = msz + 4'd1;
			pbits = '0;
			pcount = '0;
			pack_code(clr[11:0], code_w);
			prefix = 12'(sym);
		end else begin
			hit = 0;
			for (c = clr + 13'd2; c < next_code; c++)
				if (dict_prefix[c[11:0]] == prefix && dict_sym[c[11:0]] == sym) begin
					hit = 1;
					break;
				end
			if (hit) begin
				prefix = c[11:0];
			end else begin
				pack_code(prefix, code_w);
				if (next_code < DICT_CODES_DEF) begin
					dict_prefix[next_code[11:0]] = prefix;
					dict_sym[next_code[11:0]] = sym;
					if (next_code == (13'd1 << code_w) && code_w < MAX_WIDTH)
						code_w++;
					next_code++;
				end else begin
					// dictionary full: clear and restart
					pack_code(clr[11:0], code_w);
					next_code = clr + 13'd2;
					code_w = msz + 4'd1;
				end
				prefix = 12'(sym);
			end
		end
		if (fend) begin
			pack_code(prefix, code_w);
			pack_code(clr[11:0] + 12'd1, code_w);
			if (pcount != 0) add_byte(pbits);
			if (byte_q.size() > first_out) byte_q[byte_q.size()-1].last = 1;
			pbits = '0;
			pcount = '0;
			framing = 0;
		end
	endtask

	// driver: feeds symbols and register writes from the pending queue
	always @(posedge clk) begin
		bit cfg_go;
		cfg_go = 0;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				lzw_encode(s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid && byte_q.size() == 0) quiet++;
			else quiet = 0;
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (pending_q.size() > 0 && pending_q[0].is_cfg) begin
					s_axis_tvalid <= 0;
					if (!(s_axis_tvalid && s_axis_tready) && byte_q.size() == 0 &&
						quiet >= 20) begin
						cfg_go = 1;
						cfg_wdata <= pending_q[0].cfg;
						if (!framing) size_reg = pending_q[0].cfg;
						void'(pending_q.pop_front());
						quiet = 0;
					end
				end else if (pending_q.size() > 0 &&
					(pending_q[0].calm || $urandom_range(99) >= 31)) begin
					s_axis_tvalid <= 1;
					s_axis_tdata <= pending_q[0].sym;
					s_axis_tlast <= pending_q[0].last;
					calm_now = pending_q[0].calm;
					void'(pending_q.pop_front());
				end else begin
					s_axis_tvalid <= 0;
				end
			end
			cfg_we <= cfg_go;
		end
	end

	// monitor: random back-pressure and byte checks
	always @(posedge clk) begin
		lzw_byte_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (byte_q.size() == 0) begin
					$error("unexpected byte %02h", m_axis_tdata);
					errors++;
				end else begin
					want = byte_q.pop_front();
					if (m_axis_tdata !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata);
						errors++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last_byte: expected %0b, got %0b", want.last, m_axis_tlast);
						errors++;
					end
				end
			end
			m_axis_tready <= calm_now || $urandom_range(99) >= 31;
		end
	end

	task automatic add_cfg(input logic [3:0] v);
		stim_t t;
		t = '{1'b1, v, 8'h00, 1'b0, 1'b0};
		pending_q.insert(pending_q.size(), t);
	endtask

	task automatic add_sym(input logic [7:0] s, input bit l, input bit c = 0);
		stim_t t;
		t = '{1'b0, 4'h0, s, l, c};
		pending_q.insert(pending_q.size(), t);
	endtask

	// stimulus
	initial begin
		int n, mode, len;
		logic [3:0] sz;
		logic [7:0] mask;
		// directed: extremes, one-symbol frame, wide symbols, odd sizes
		add_cfg(4'd8);
		add_sym(8'h00, 0); add_sym(8'hFF, 0); add_sym(8'h00, 0); add_sym(8'hFF, 1);
		add_sym(8'hAA, 1);
		add_cfg(4'd2);
		for (int i = 0; i < 9; i++) add_sym(8'h00, i == 8);
		add_cfg(4'd0);
		add_sym(8'hFF, 0); add_sym(8'h55, 0); add_sym(8'hFE, 1);
		add_cfg(4'd15);
		add_sym(8'h81, 1);
		add_cfg(4'd9);
		add_sym(8'h7F, 0); add_sym(8'h7F, 1);
		add_cfg(4'd1);
		add_sym(8'h03, 1);
		// one longer frame at the smallest size so the code widens a few times
		add_cfg(4'd2);
		for (int i = 0; i < 40; i++) add_sym(8'($urandom), i == 39, i >= 5 && i < 35);
		// random frames, mostly in-range symbols
		n = 0;
		while (n < 40) begin
			sz = 4'($urandom_range(15));
			add_cfg(sz);
			mask = (sz < 2) ? 8'h03 : (sz > 8) ? 8'hFF : 8'((9'd1 << sz) - 1);
			len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 25);
			mode = $urandom_range(3);
			for (int i = 0; i < len; i++) begin
				logic [7:0] s;
				s = 8'($urandom);
				if ($urandom_range(9) != 0) s &= mask;
				if (mode == 0) s &= 8'h01;
				add_sym(s, i == len - 1, 0);
				n++;
			end
		end
		repeat (8) @(posedge clk);
		arst_n <= 1;
		wait (pending_q.size() == 0 && !s_axis_tvalid && byte_q.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
